// ===== src/phd_pkg.sv =====
package phd_pkg;

	localparam int CNT_W  = 10;
	localparam int DIST_W = 4;
	localparam int TIER_W = 3;
	localparam int STRK_W = 2;

	localparam logic [STRK_W-1:0] STREAK_MAX = 2'd2;
	localparam logic [TIER_W-1:0] TIER_FAR   = 3'd5;

	localparam logic [CNT_W-1:0] RST_PULSE_ON = 10'd100;
	localparam logic [CNT_W-1:0] RST_IDLE     = 10'd50;
	localparam logic [CNT_W-1:0] RST_DISABLED = 10'd100;

	typedef enum logic [1:0] {
		REG_NO_READING = 2'd0,
		REG_PULSE_ON   = 2'd1,
		REG_IDLE_POLL  = 2'd2,
		REG_DIS_POLL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DIST_W-1:0] no_reading_level;
		logic [CNT_W-1:0]  pulse_on_ticks;
		logic [CNT_W-1:0]  idle_poll_ticks;
		logic [CNT_W-1:0]  disabled_poll_ticks;
	} cfg_t;

	function automatic logic [TIER_W-1:0] tier_of(
		input logic [DIST_W-1:0] feet,
		input logic [DIST_W-1:0] level
	);
		logic [TIER_W-1:0] t;
		if (feet <= level) begin
			t = '0;
		end else if (feet <= 4'd2) begin
			t = 3'd1;
		end else if (feet <= 4'd6) begin
			t = TIER_W'(feet - 4'd1);
		end else begin
			t = '0;
		end
		return t;
	endfunction

	function automatic logic [CNT_W-1:0] gap_of(input logic [TIER_W-1:0] tier);
		logic [CNT_W-1:0] g;
		case (tier)
			3'd1:    g = 10'd100;
			3'd2:    g = 10'd300;
			3'd3:    g = 10'd500;
			3'd4:    g = 10'd700;
			3'd5:    g = 10'd900;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== src/phd_cfg.sv =====
module phd_cfg
	import phd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.no_reading_level    <= '0;
			cfg_q.pulse_on_ticks      <= RST_PULSE_ON;
			cfg_q.idle_poll_ticks     <= RST_IDLE;
			cfg_q.disabled_poll_ticks <= RST_DISABLED;
		end else if (wr) begin
			case (idx)
				REG_NO_READING: cfg_q.no_reading_level    <= pwdata[DIST_W-1:0];
				REG_PULSE_ON:   cfg_q.pulse_on_ticks      <= pwdata[CNT_W-1:0];
				REG_IDLE_POLL:  cfg_q.idle_poll_ticks     <= pwdata[CNT_W-1:0];
				REG_DIS_POLL:   cfg_q.disabled_poll_ticks <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NO_READING: prdata = 32'(cfg_q.no_reading_level);
			REG_PULSE_ON:   prdata = 32'(cfg_q.pulse_on_ticks);
			REG_IDLE_POLL:  prdata = 32'(cfg_q.idle_poll_ticks);
			REG_DIS_POLL:   prdata = 32'(cfg_q.disabled_poll_ticks);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== src/phd_lane.sv =====
module phd_lane
	import phd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              enable,
	input  logic [DIST_W-1:0] feet,
	input  cfg_t              cfg,
	output logic              motor_nxt
);

	logic [CNT_W-1:0]  cnt_q, cnt_d, dec;
	logic              phase_q, phase_d;
	logic [STRK_W-1:0] streak_q, streak_d;
	logic              active_q, active_d;
	logic [TIER_W-1:0] tier_q, tier_d;
	logic              motor_q, motor_d;
	logic [TIER_W-1:0] t;

	assign dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
	assign t   = tier_of(feet, cfg.no_reading_level);

	always_comb begin
		cnt_d    = dec;
		phase_d  = phase_q;
		streak_d = streak_q;
		active_d = active_q;
		tier_d   = tier_q;
		motor_d  = motor_q;
		if (dec == '0) begin
			if (phase_q) begin
				motor_d = 1'b0;
				cnt_d   = gap_of(tier_q);
				phase_d = 1'b0;
			end else if (!enable) begin
				motor_d  = 1'b0;
				streak_d = '0;
				active_d = 1'b0;
				cnt_d    = cfg.disabled_poll_ticks;
			end else begin
				if (t == TIER_FAR) begin
					if (streak_q < STREAK_MAX) begin
						streak_d = streak_q + 1'b1;
					end
					if (streak_d >= STREAK_MAX) begin
						active_d = 1'b1;
					end
				end else if (t != '0) begin
					streak_d = '0;
					active_d = 1'b1;
				end else begin
					streak_d = '0;
					active_d = 1'b0;
				end
				if (!active_d) begin
					motor_d = 1'b0;
					cnt_d   = cfg.idle_poll_ticks;
				end else begin
					tier_d  = t;
					motor_d = 1'b1;
					cnt_d   = cfg.pulse_on_ticks;
					phase_d = 1'b1;
				end
			end
		end
	end

	assign motor_nxt = motor_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			phase_q  <= 1'b0;
			streak_q <= '0;
			active_q <= 1'b0;
			tier_q   <= '0;
			motor_q  <= 1'b0;
		end else if (advance) begin
			cnt_q    <= cnt_d;
			phase_q  <= phase_d;
			streak_q <= streak_d;
			active_q <= active_d;
			tier_q   <= tier_d;
			motor_q  <= motor_d;
		end
	end

	a_motor_phase: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q == phase_q)
		else $error("motor drive out of step with pulse phase");

	a_pulse_tier: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (tier_q != '0 && tier_q <= TIER_FAR))
		else $error("pulse running with invalid tier");

	a_streak_sat: assert property (@(posedge clk) disable iff (!arst_n)
		streak_q <= STREAK_MAX)
		else $error("far streak above saturation");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cnt_q > 10'd1) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("wait counter skipped a tick");

endmodule

// ===== src/phd_merge.sv =====
module phd_merge #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [NUM_CHANNELS-1:0] motor_nxt,
	input  logic                    m_axis_tready,
	output logic                    m_axis_tvalid,
	output logic [NUM_CHANNELS-1:0] motor_bits
);

	logic                    valid_q;
	logic [NUM_CHANNELS-1:0] bits_q;

	assign m_axis_tvalid = valid_q;
	assign motor_bits    = bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q <= motor_nxt;
		end
	end

endmodule

// ===== src/proximity_haptic_pulse_driver.sv =====
// Four-channel (NUM_CHANNELS) proximity haptic pulse driver.
// Each slave item is one 1 ms tick: bit 0 of s_axis_tdata is haptics_enable,
// and each channel c takes its 4-bit distance from bits [4c+4:4c+1].
// Every tick yields exactly one master item whose bit c is the motor drive
// of channel c after that tick.
// Configuration goes through the APB port: register 0 no_reading_level
// (addr 0x0), 1 pulse_on_ticks (0x4), 2 idle_poll_ticks (0x8),
// 3 disabled_poll_ticks (0xC). Write them only while the block is idle.
// The result of a tick is valid in the cycle after it is accepted.
// Throughput is one item per cycle while the receiver does not stall; each
// channel lane updates its countdown and pulse state, and the output
// register holds the result.
// s_axis_tready is high while the output register is empty or being taken
// in the same cycle; if the receiver stalls, the result holds and the
// next tick waits, so no tick is lost.
// Reset clears all channels (motors off, sample on the first tick) and loads
// the register defaults 0, 100, 50 and 100.
module proximity_haptic_pulse_driver
	import phd_pkg::*;
#(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// haptics_enable, distance_0 .. distance_(NUM_CHANNELS-1), zero pad
	input  logic [((1 + DIST_W * NUM_CHANNELS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// motor_on_0 .. motor_on_(NUM_CHANNELS-1), zero pad
	output logic [((NUM_CHANNELS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int OUT_W = ((NUM_CHANNELS + 7) / 8) * 8;

	cfg_t                    cfg;
	logic                    accept;
	logic [NUM_CHANNELS-1:0] motor_nxt;
	logic [NUM_CHANNELS-1:0] motor_bits;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	phd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
		phd_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (accept),
			.enable    (s_axis_tdata[0]),
			.feet      (s_axis_tdata[DIST_W*c+1 +: DIST_W]),
			.cfg       (cfg),
			.motor_nxt (motor_nxt[c])
		);
	end

	phd_merge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.motor_nxt     (motor_nxt),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.motor_bits    (motor_bits)
	);

	assign m_axis_tdata = OUT_W'(motor_bits);

endmodule
